// ----- rtl/ucd_pkg.sv -----
// ---------------------------------------------------------------------------
// ucd_pkg: shared constants and types for the seconds-to-civil-date pipeline
// Stage count, enable vector type, reciprocal constants and the month table.
// ---------------------------------------------------------------------------
`default_nettype none

package ucd_pkg;

    // Pipeline depth: 3 stages of day split, 8 of year search, 2 of month/day.
    localparam int NUM_STAGES = 13;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    // Field widths
    localparam int SECS_W  = 38;
    localparam int DAYS_W  = 22;
    localparam int SOD_W   = 17;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int DOY_W   = 9;

    // Seconds per day = 128 * 675. Divide (t >> 7) by 675.
    localparam int          DAY_LOW_W  = 7;
    localparam logic [9:0]  DAY_DIV    = 10'd675;
    localparam logic [21:0] DAY_RECIP  = 22'd3181457;   // floor(2^31 / 675)
    localparam int          DAY_SHIFT  = 31;

    // Day count from March 1 of year 0
    localparam logic [21:0] EPOCH_DAY_OFFSET = 22'd719468;

    // Year guess: (400 * g + 591) / 146097, with g = days + offset folded in
    localparam logic [30:0] YEAR_SCALE      = 31'd400;
    localparam logic [30:0] YEAR_NUM_OFFSET = 31'd287787791; // 400 * 719468 + 591
    localparam logic [17:0] CYCLE_DAYS      = 18'd146097;
    localparam logic [13:0] YEAR_RECIP      = 14'd14699;     // floor(2^31 / 146097)
    localparam int          YEAR_SHIFT      = 31;

    // Century count y / 100, exact for y below 43699
    localparam logic [12:0] CENT_RECIP = 13'd5243;
    localparam int          CENT_SHIFT = 19;
    localparam logic [13:0] CENT_YEARS = 14'd100;
    localparam logic [21:0] YEAR_DAYS  = 22'd365;

    // Month index (5 * doy + 2) / 153, exact for numerators below 12192
    localparam logic [10:0] MON_SCALE  = 11'd5;
    localparam logic [10:0] MON_BIAS   = 11'd2;
    localparam logic [12:0] MON_RECIP  = 13'd6854;      // ceil(2^20 / 153)
    localparam int          MON_SHIFT  = 20;
    localparam logic [3:0]  MON_WRAP   = 4'd10;         // January in a March year

    // Time of day
    localparam logic [11:0] HOUR_SECS  = 12'd3600;
    localparam logic [8:0]  HOUR_RECIP = 9'd291;        // floor(2^20 / 3600)
    localparam int          HOUR_SHIFT = 20;
    localparam logic [11:0] MIN_SECS   = 12'd60;
    localparam logic [6:0]  MIN_RECIP  = 7'd68;         // floor(2^12 / 60)
    localparam int          MIN_SHIFT  = 12;

    // Days in a March-based year before month index mi: (306 * mi + 5) / 10
    function automatic logic [DOY_W-1:0] days_before_month(input logic [3:0] mi);
        logic [DOY_W-1:0] d;
        unique case (mi)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/unix_seconds_to_civil_date.sv -----
// ---------------------------------------------------------------------------
// unix_seconds_to_civil_date: Unix seconds to Gregorian date and time of day
// Thirteen-stage pipeline; one timestamp in and one date out per cycle while i_ready is high.
// ---------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  in       i_valid / o_ready    i_unix_seconds[37:0]
//  out      o_valid / i_ready    o_year, o_month, o_day_of_month,
//                                o_hour, o_minute, o_second
//
//  Throughput is one transfer per cycle while i_ready is high. The stages
//  are 3 day split, 8 year search and 2 month/day; the time of day runs
//  alongside in 6 stages plus a delay line.
//  Reset clears only the stage valid bits; data registers are not reset.
//  Each stage holds while its successor is full and stalled, so a stall
//  backs up stage by stage and empty stages keep filling; o_ready stays
//  high until every stage holds an item.
//
// Flow:
//   days = t / 86400 and the seconds of day, both by reciprocal multiply
//   with a one-step remainder fixup. The days move to a count from March 1
//   of year 0, the year is guessed as (400 g + 591) / 146097 and fixed up,
//   then stepped back once if it overshoots the day count. The month index comes from
//   (5 doy + 2) / 153, and January/February roll into the next civil year.
// ---------------------------------------------------------------------------
`default_nettype none

module unix_seconds_to_civil_date (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input channel
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [ucd_pkg::SECS_W-1:0]   i_unix_seconds,
    // output channel
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [ucd_pkg::YEAR_W-1:0]   o_year,
    output logic      [ucd_pkg::MONTH_W-1:0]  o_month,
    output logic      [ucd_pkg::DOM_W-1:0]    o_day_of_month,
    output logic      [ucd_pkg::HOUR_W-1:0]   o_hour,
    output logic      [ucd_pkg::MIN_W-1:0]    o_minute,
    output logic      [ucd_pkg::SEC_W-1:0]    o_second
);

    localparam int LAST = ucd_pkg::NUM_STAGES - 1;

    ucd_pkg::t_stage_en r_valid;   // one valid bit per stage
    ucd_pkg::t_stage_en w_en;      // stage load enables

    logic [ucd_pkg::DAYS_W-1:0] w_days;
    logic [ucd_pkg::SOD_W-1:0]  w_sod;
    logic [ucd_pkg::YEAR_W-1:0] w_myear;
    logic [ucd_pkg::DOY_W-1:0]  w_doy;

    // A stage loads when it is empty or its content moves on this cycle.
    always_comb begin
        w_en[LAST] = !r_valid[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_valid[LAST];

    // stages 0-2
    ucd_day_split u_day_split (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_secs (i_unix_seconds),
        .o_days (w_days),
        .o_sod  (w_sod)
    );

    // stages 3-10
    ucd_year u_year (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_days (w_days),
        .o_year (w_myear),
        .o_doy  (w_doy)
    );

    // stages 11-12
    ucd_month_day u_month_day (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_year         (w_myear),
        .i_doy          (w_doy),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month)
    );

    // stages 3-12, time of day
    ucd_clock u_clock (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sod    (w_sod),
        .o_hour   (o_hour),
        .o_minute (o_minute),
        .o_second (o_second)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Month index and day fit must give a month of 1 to 12 and a nonzero day.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1) && (o_month <= 4'd12)
                    && (o_day_of_month != 5'd0))
        else $error("date fields out of range");

    // Remainder fixups must leave a proper time of day.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour <= 5'd23) && (o_minute <= 6'd59) && (o_second <= 6'd59))
        else $error("time fields out of range");

    // With the sink ready the whole pipeline advances, so input is taken.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("pipeline stalled while sink ready");

endmodule

`default_nettype wire

// ----- rtl/ucd_day_split.sv -----
// ---------------------------------------------------------------------------
// ucd_day_split: seconds to whole days and seconds of day
// Three stages: reciprocal multiply, back-multiply remainder, one-step fixup.
// ---------------------------------------------------------------------------
`default_nettype none

module ucd_day_split (
    input  wire logic                        i_clk,
    input  wire ucd_pkg::t_stage_en          i_en,
    input  wire logic [ucd_pkg::SECS_W-1:0]  i_secs,
    output logic      [ucd_pkg::DAYS_W-1:0]  o_days,
    output logic      [ucd_pkg::SOD_W-1:0]   o_sod
);

    localparam int A_W    = ucd_pkg::SECS_W - ucd_pkg::DAY_LOW_W;   // 31
    localparam int PROD_W = A_W + ucd_pkg::DAYS_W;                  // 53
    localparam int REM_W  = 11;

    // stage 0
    logic [PROD_W-1:0]             r0_prod;
    logic [A_W-1:0]                r0_a;
    logic [ucd_pkg::DAY_LOW_W-1:0] r0_lo;
    // stage 1
    logic [ucd_pkg::DAYS_W-1:0]    r1_q;
    logic [REM_W-1:0]              r1_rem;
    logic [ucd_pkg::DAY_LOW_W-1:0] r1_lo;
    // stage 2
    logic [ucd_pkg::DAYS_W-1:0]    r2_days;
    logic [ucd_pkg::SOD_W-1:0]     r2_sod;

    logic [ucd_pkg::DAYS_W-1:0]    w_q0;
    logic [A_W-1:0]                w_back;
    logic [A_W-1:0]                w_rem;
    logic [REM_W-1:0]              w_rem_fix;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_a    <= i_secs[ucd_pkg::SECS_W-1:ucd_pkg::DAY_LOW_W];
            r0_lo   <= i_secs[ucd_pkg::DAY_LOW_W-1:0];
            r0_prod <= PROD_W'(i_secs[ucd_pkg::SECS_W-1:ucd_pkg::DAY_LOW_W])
                       * PROD_W'(ucd_pkg::DAY_RECIP);
        end
    end

    assign w_q0   = r0_prod[PROD_W-1:ucd_pkg::DAY_SHIFT];
    assign w_back = A_W'(A_W'(w_q0) * A_W'(ucd_pkg::DAY_DIV));
    assign w_rem  = r0_a - w_back;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_q   <= w_q0;
            r1_rem <= w_rem[REM_W-1:0];
            r1_lo  <= r0_lo;
        end
    end

    // estimate is low by at most one
    assign w_rem_fix = r1_rem - REM_W'(ucd_pkg::DAY_DIV);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            if (r1_rem >= REM_W'(ucd_pkg::DAY_DIV)) begin
                r2_days <= r1_q + 1'b1;
                r2_sod  <= {w_rem_fix[9:0], r1_lo};
            end else begin
                r2_days <= r1_q;
                r2_sod  <= {r1_rem[9:0], r1_lo};
            end
        end
    end

    assign o_days = r2_days;
    assign o_sod  = r2_sod;

endmodule

`default_nettype wire

// ----- rtl/ucd_year.sv -----
// ---------------------------------------------------------------------------
// ucd_year: day count to March-based year and day of year
// Eight stages: year guess by reciprocal, fixup, days before year, compare
// and step back one year on overshoot.
// ---------------------------------------------------------------------------
`default_nettype none

module ucd_year (
    input  wire logic                        i_clk,
    input  wire ucd_pkg::t_stage_en          i_en,
    input  wire logic [ucd_pkg::DAYS_W-1:0]  i_days,
    output logic      [ucd_pkg::YEAR_W-1:0]  o_year,
    output logic      [ucd_pkg::DOY_W-1:0]   o_doy
);

    localparam int G_W    = ucd_pkg::DAYS_W;      // 22
    localparam int Y_W    = ucd_pkg::YEAR_W;      // 14
    localparam int NUM_W  = 31;
    localparam int PROD_W = NUM_W + Y_W;          // 45
    localparam int YREM_W = 19;
    localparam int CP_W   = 27;
    localparam int C_W    = 7;

    // stage 3
    logic [G_W-1:0]    r3_g;
    logic [NUM_W-1:0]  r3_num;
    // stage 4
    logic [G_W-1:0]    r4_g;
    logic [NUM_W-1:0]  r4_num;
    logic [PROD_W-1:0] r4_prod;
    // stage 5
    logic [G_W-1:0]    r5_g;
    logic [Y_W-1:0]    r5_y0;
    logic [YREM_W-1:0] r5_rem;
    // stage 6
    logic [G_W-1:0]    r6_g;
    logic [Y_W-1:0]    r6_y;
    // stage 7
    logic [G_W-1:0]    r7_g;
    logic [Y_W-1:0]    r7_y;
    logic [G_W-1:0]    r7_y365;
    logic [C_W-1:0]    r7_c;
    // stage 8
    logic [G_W-1:0]    r8_g;
    logic [Y_W-1:0]    r8_y;
    logic [G_W-1:0]    r8_dby;
    logic              r8_leap;
    // stage 9
    logic [G_W:0]      r9_diff;
    logic [Y_W-1:0]    r9_y;
    logic              r9_leap;
    // stage 10
    logic [Y_W-1:0]    r10_y;
    logic [ucd_pkg::DOY_W-1:0] r10_doy;

    logic [Y_W-1:0]    w_y0;
    logic [NUM_W-1:0]  w_back;
    logic [NUM_W-1:0]  w_rem;
    logic [CP_W-1:0]   w_cprod;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_g   <= i_days + ucd_pkg::EPOCH_DAY_OFFSET;
            r3_num <= NUM_W'(NUM_W'(i_days) * ucd_pkg::YEAR_SCALE)
                      + ucd_pkg::YEAR_NUM_OFFSET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_g    <= r3_g;
            r4_num  <= r3_num;
            r4_prod <= PROD_W'(r3_num) * PROD_W'(ucd_pkg::YEAR_RECIP);
        end
    end

    assign w_y0   = r4_prod[PROD_W-1:ucd_pkg::YEAR_SHIFT];
    assign w_back = NUM_W'(NUM_W'(w_y0) * NUM_W'(ucd_pkg::CYCLE_DAYS));
    assign w_rem  = r4_num - w_back;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r5_g   <= r4_g;
            r5_y0  <= w_y0;
            r5_rem <= w_rem[YREM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r6_g <= r5_g;
            if (r5_rem >= YREM_W'(ucd_pkg::CYCLE_DAYS)) begin
                r6_y <= r5_y0 + 1'b1;
            end else begin
                r6_y <= r5_y0;
            end
        end
    end

    // y / 100 by exact reciprocal; 365 * y + y / 4 alongside
    assign w_cprod = CP_W'(r6_y) * CP_W'(ucd_pkg::CENT_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r7_g    <= r6_g;
            r7_y    <= r6_y;
            r7_c    <= w_cprod[ucd_pkg::CENT_SHIFT+C_W-1:ucd_pkg::CENT_SHIFT];
            r7_y365 <= G_W'(G_W'(r6_y) * ucd_pkg::YEAR_DAYS) + G_W'(r6_y[Y_W-1:2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r8_g    <= r7_g;
            r8_y    <= r7_y;
            r8_dby  <= r7_y365 - G_W'(r7_c) + G_W'(r7_c[C_W-1:2]);
            // dby(y) - dby(y-1) - 365: Gregorian leap rule applied to y
            r8_leap <= (r7_y[1:0] == 2'b00)
                       && ((r7_y != Y_W'(Y_W'(r7_c) * ucd_pkg::CENT_YEARS))
                           || (r7_c[1:0] == 2'b00));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[9]) begin
            r9_diff <= {1'b0, r8_g} - {1'b0, r8_dby};
            r9_y    <= r8_y;
            r9_leap <= r8_leap;
        end
    end

    // guess overshoots by at most one year
    always_ff @(posedge i_clk) begin
        if (i_en[10]) begin
            if (r9_diff[G_W]) begin
                r10_y   <= r9_y - 1'b1;
                r10_doy <= r9_diff[ucd_pkg::DOY_W-1:0]
                           + ucd_pkg::DOY_W'(ucd_pkg::YEAR_DAYS)
                           + ucd_pkg::DOY_W'(r9_leap);
            end else begin
                r10_y   <= r9_y;
                r10_doy <= r9_diff[ucd_pkg::DOY_W-1:0];
            end
        end
    end

    assign o_year = r10_y;
    assign o_doy  = r10_doy;

endmodule

`default_nettype wire

// ----- rtl/ucd_month_day.sv -----
// ---------------------------------------------------------------------------
// ucd_month_day: March-based day of year to civil year, month and day
// Two stages: month index by reciprocal, then table lookup and renumbering.
// ---------------------------------------------------------------------------
`default_nettype none

module ucd_month_day (
    input  wire logic                         i_clk,
    input  wire ucd_pkg::t_stage_en           i_en,
    input  wire logic [ucd_pkg::YEAR_W-1:0]   i_year,
    input  wire logic [ucd_pkg::DOY_W-1:0]    i_doy,
    output logic      [ucd_pkg::YEAR_W-1:0]   o_year,
    output logic      [ucd_pkg::MONTH_W-1:0]  o_month,
    output logic      [ucd_pkg::DOM_W-1:0]    o_day_of_month
);

    localparam int X_W    = 11;
    localparam int PROD_W = 24;

    logic [PROD_W-1:0]              r11_prod;
    logic [ucd_pkg::DOY_W-1:0]      r11_doy;
    logic [ucd_pkg::YEAR_W-1:0]     r11_year;

    logic [ucd_pkg::YEAR_W-1:0]     r12_year;
    logic [ucd_pkg::MONTH_W-1:0]    r12_month;
    logic [ucd_pkg::DOM_W-1:0]      r12_dom;

    logic [X_W-1:0]                 w_x;
    logic [ucd_pkg::MONTH_W-1:0]    w_mi;
    logic [ucd_pkg::DOY_W-1:0]      w_dom;
    logic                           w_wrap;

    assign w_x = X_W'(X_W'(i_doy) * ucd_pkg::MON_SCALE) + ucd_pkg::MON_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_en[11]) begin
            r11_prod <= PROD_W'(w_x) * PROD_W'(ucd_pkg::MON_RECIP);
            r11_doy  <= i_doy;
            r11_year <= i_year;
        end
    end

    assign w_mi   = r11_prod[ucd_pkg::MON_SHIFT+ucd_pkg::MONTH_W-1:ucd_pkg::MON_SHIFT];
    assign w_wrap = (w_mi >= ucd_pkg::MON_WRAP);
    assign w_dom  = r11_doy - ucd_pkg::days_before_month(w_mi) + 1'b1;

    // January and February belong to the next civil year
    always_ff @(posedge i_clk) begin
        if (i_en[12]) begin
            r12_year  <= r11_year + ucd_pkg::YEAR_W'(w_wrap);
            r12_month <= w_wrap ? (w_mi - 4'd9) : (w_mi + 4'd3);
            r12_dom   <= w_dom[ucd_pkg::DOM_W-1:0];
        end
    end

    assign o_year         = r12_year;
    assign o_month        = r12_month;
    assign o_day_of_month = r12_dom;

endmodule

`default_nettype wire

// ----- rtl/ucd_clock.sv -----
// ---------------------------------------------------------------------------
// ucd_clock: seconds of day to hour, minute and second
// Two reciprocal divisions of three stages each, then a delay line that
// keeps the time of day in step with the date lane.
// ---------------------------------------------------------------------------
`default_nettype none

module ucd_clock (
    input  wire logic                        i_clk,
    input  wire ucd_pkg::t_stage_en          i_en,
    input  wire logic [ucd_pkg::SOD_W-1:0]   i_sod,
    output logic      [ucd_pkg::HOUR_W-1:0]  o_hour,
    output logic      [ucd_pkg::MIN_W-1:0]   o_minute,
    output logic      [ucd_pkg::SEC_W-1:0]   o_second
);

    localparam int HP_W  = 26;
    localparam int HR_W  = 13;
    localparam int MR_W  = 12;
    localparam int MP_W  = 18;
    localparam int SR_W  = 7;
    localparam int DLY_N = 4;     // stages 9 to 12

    logic [HP_W-1:0]             r3_prod;
    logic [ucd_pkg::SOD_W-1:0]   r3_sod;
    logic [ucd_pkg::HOUR_W-1:0]  r4_h0;
    logic [HR_W-1:0]             r4_rem;
    logic [ucd_pkg::HOUR_W-1:0]  r5_hour;
    logic [MR_W-1:0]             r5_rem;
    logic [ucd_pkg::HOUR_W-1:0]  r6_hour;
    logic [MR_W-1:0]             r6_rem;
    logic [MP_W-1:0]             r6_prod;
    logic [ucd_pkg::HOUR_W-1:0]  r7_hour;
    logic [ucd_pkg::MIN_W-1:0]   r7_m0;
    logic [SR_W-1:0]             r7_rem;
    logic [ucd_pkg::HOUR_W-1:0]  r8_hour;
    logic [ucd_pkg::MIN_W-1:0]   r8_minute;
    logic [ucd_pkg::SEC_W-1:0]   r8_second;

    logic [ucd_pkg::HOUR_W-1:0]  r_hour_dly   [DLY_N];
    logic [ucd_pkg::MIN_W-1:0]   r_minute_dly [DLY_N];
    logic [ucd_pkg::SEC_W-1:0]   r_second_dly [DLY_N];

    logic [ucd_pkg::HOUR_W-1:0]  w_h0;
    logic [ucd_pkg::SOD_W-1:0]   w_hback;
    logic [ucd_pkg::SOD_W-1:0]   w_hrem;
    logic [ucd_pkg::MIN_W-1:0]   w_m0;
    logic [MR_W-1:0]             w_mback;
    logic [MR_W-1:0]             w_mrem;
    logic [SR_W-1:0]             w_sfix;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_prod <= HP_W'(i_sod) * HP_W'(ucd_pkg::HOUR_RECIP);
            r3_sod  <= i_sod;
        end
    end

    assign w_h0    = r3_prod[ucd_pkg::HOUR_SHIFT+ucd_pkg::HOUR_W-1:ucd_pkg::HOUR_SHIFT];
    assign w_hback = ucd_pkg::SOD_W'(ucd_pkg::SOD_W'(w_h0) * ucd_pkg::SOD_W'(ucd_pkg::HOUR_SECS));
    assign w_hrem  = r3_sod - w_hback;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_h0  <= w_h0;
            r4_rem <= w_hrem[HR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            if (r4_rem >= HR_W'(ucd_pkg::HOUR_SECS)) begin
                r5_hour <= r4_h0 + 1'b1;
                r5_rem  <= MR_W'(r4_rem - HR_W'(ucd_pkg::HOUR_SECS));
            end else begin
                r5_hour <= r4_h0;
                r5_rem  <= r4_rem[MR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r6_prod <= MP_W'(r5_rem) * MP_W'(ucd_pkg::MIN_RECIP);
            r6_rem  <= r5_rem;
            r6_hour <= r5_hour;
        end
    end

    assign w_m0    = r6_prod[ucd_pkg::MIN_SHIFT+ucd_pkg::MIN_W-1:ucd_pkg::MIN_SHIFT];
    assign w_mback = MR_W'(MR_W'(w_m0) * ucd_pkg::MIN_SECS);
    assign w_mrem  = r6_rem - w_mback;

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r7_m0   <= w_m0;
            r7_rem  <= w_mrem[SR_W-1:0];
            r7_hour <= r6_hour;
        end
    end

    assign w_sfix = r7_rem - SR_W'(ucd_pkg::MIN_SECS);

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r8_hour <= r7_hour;
            if (r7_rem >= SR_W'(ucd_pkg::MIN_SECS)) begin
                r8_minute <= r7_m0 + 1'b1;
                r8_second <= w_sfix[ucd_pkg::SEC_W-1:0];
            end else begin
                r8_minute <= r7_m0;
                r8_second <= r7_rem[ucd_pkg::SEC_W-1:0];
            end
        end
    end

    // align with the date lane
    always_ff @(posedge i_clk) begin
        if (i_en[9]) begin
            r_hour_dly[0]   <= r8_hour;
            r_minute_dly[0] <= r8_minute;
            r_second_dly[0] <= r8_second;
        end
        for (int k = 1; k < DLY_N; k++) begin
            if (i_en[9+k]) begin
                r_hour_dly[k]   <= r_hour_dly[k-1];
                r_minute_dly[k] <= r_minute_dly[k-1];
                r_second_dly[k] <= r_second_dly[k-1];
            end
        end
    end

    assign o_hour   = r_hour_dly[DLY_N-1];
    assign o_minute = r_minute_dly[DLY_N-1];
    assign o_second = r_second_dly[DLY_N-1];

endmodule

`default_nettype wire
